// File: rtl/core/mcc_pkg.sv
// Shared types and constants for the magnetometer correction and calibration block.
// Holds the item structs, the controller-to-datapath command struct and register codes.
// No dependencies.
package mcc_pkg;

    localparam int FRAC_BITS = 14;
    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam int DATA_W    = 16;

    // Range is at most 65535, so the sum of three ranges needs 18 bits.
    localparam int SUM_W     = 18;
    localparam int DEN_W     = 18;
    localparam int NUM_W     = SUM_W + FRAC_BITS;
    localparam int CMP_W     = DEN_W + DATA_W;
    localparam int DIV_STEPS = DATA_W;
    localparam int STEP_W    = 4;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z   = 3'd5;

    localparam logic [DATA_W-1:0] GAIN_ONE  = DATA_W'(1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] SCALE_MAX = {DATA_W{1'b1}};

    typedef struct packed {
        logic signed [DATA_W-1:0] raw_x;
        logic signed [DATA_W-1:0] raw_y;
        logic signed [DATA_W-1:0] raw_z;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] corr_x;
        logic signed [DATA_W-1:0] corr_y;
        logic signed [DATA_W-1:0] corr_z;
        logic signed [DATA_W-1:0] cal_off_x;
        logic signed [DATA_W-1:0] cal_off_y;
        logic signed [DATA_W-1:0] cal_off_z;
        logic        [DATA_W-1:0] cal_scale_x;
        logic        [DATA_W-1:0] cal_scale_y;
        logic        [DATA_W-1:0] cal_scale_z;
        logic                     range_zero;
    } out_item_t;

    typedef struct packed {
        logic              load_in;
        logic              mul;
        logic              upd;
        logic              div_load;
        logic              div_step;
        logic              div_store;
        logic              out_load;
        logic [AXIS_W-1:0] axis;
    } mcc_cmd_t;

endpackage

// File: rtl/core/mcc_ctrl.sv
// Sequencing controller for the magnetometer correction and calibration block.
// Steps the datapath through correction, tracking and serial division per axis.
// Depends on mcc_pkg.
module mcc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output mcc_pkg::mcc_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_DLD   = 3'd3;
    localparam logic [2:0] S_DSTEP = 3'd4;
    localparam logic [2:0] S_DEND  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]                   state_reg, state_next;
    logic [mcc_pkg::AXIS_W-1:0]   axis_reg, axis_next;
    logic [mcc_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         last_axis;

    assign last_axis = (axis_reg == mcc_pkg::AXIS_W'(mcc_pkg::AXES - 1));
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    axis_next   = '0;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd = 1'b1;
                if (last_axis)
                begin
                    axis_next  = '0;
                    state_next = S_DLD;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_DLD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == mcc_pkg::STEP_W'(mcc_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_DEND;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DEND:
            begin
                cmd.div_store = 1'b1;
                if (last_axis)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_DLD;
                end
            end
            S_FIN:
            begin
                // The result register must be free or emptying this cycle.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/mcc_dp.sv
// Datapath of the magnetometer correction and calibration block: configuration
// registers, shared multiplier, min/max tracking, serial divider, result register.
// Depends on mcc_pkg.
module mcc_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mcc_pkg::mcc_cmd_t                  cmd,
    input  mcc_pkg::in_item_t                  in_data,
    input  logic                               cfg_wr,
    input  logic [mcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcc_pkg::DATA_W-1:0]         cfg_data,
    output mcc_pkg::out_item_t                 out_data
);

    localparam int DW   = mcc_pkg::DATA_W;
    localparam int PW   = 2 * DW + 2;

    localparam logic signed [PW-1:0] POS_LIM = PW'(32767);
    localparam logic signed [PW-1:0] NEG_LIM = -PW'(32768);

    logic signed [DW-1:0] off_reg   [mcc_pkg::AXES];
    logic        [DW-1:0] gain_reg  [mcc_pkg::AXES];
    logic signed [DW-1:0] raw_reg   [mcc_pkg::AXES];
    logic signed [DW-1:0] corr_reg  [mcc_pkg::AXES];
    logic signed [DW-1:0] max_reg   [mcc_pkg::AXES];
    logic signed [DW-1:0] min_reg   [mcc_pkg::AXES];
    logic        [DW-1:0] scale_reg [mcc_pkg::AXES];

    logic signed [PW-1:0]            prod_reg, prod_next;
    logic signed [PW-1:0]            shifted;
    logic signed [DW-1:0]            corr_val;
    logic        [DW-1:0]            range_val [mcc_pkg::AXES];
    logic        [mcc_pkg::SUM_W-1:0] sum_val;
    logic        [mcc_pkg::DEN_W-1:0] den_val;
    logic        [mcc_pkg::NUM_W-1:0] num_val;
    logic                            ovf_val;

    logic        [mcc_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic        [mcc_pkg::DEN_W-1:0] den_reg;
    logic        [DW-1:0]            num_lo_reg;
    logic        [DW-1:0]            quo_reg;
    logic                            sat_reg;
    logic        [mcc_pkg::DEN_W:0]  trial;
    logic        [mcc_pkg::DEN_W:0]  diff;
    logic                            take;

    logic signed [DW:0]              mid_sum [mcc_pkg::AXES];
    logic signed [DW-1:0]            mid_val [mcc_pkg::AXES];
    logic                            any_zero;
    mcc_pkg::out_item_t              out_reg;

    // Correction: (raw - offset) * gain, floor-shifted and saturated.
    always_comb
    begin
        prod_next = PW'(raw_reg[cmd.axis]) - PW'(off_reg[cmd.axis]);
        prod_next = prod_next * $signed(PW'(gain_reg[cmd.axis]));
    end

    assign shifted = prod_reg >>> mcc_pkg::FRAC_BITS;

    always_comb
    begin
        if (shifted > POS_LIM)
        begin
            corr_val = DW'(POS_LIM);
        end
        else if (shifted < NEG_LIM)
        begin
            corr_val = DW'(NEG_LIM);
        end
        else
        begin
            corr_val = shifted[DW-1:0];
        end
    end

    // Max is never negative and min never positive, so each range fits in DW bits.
    always_comb
    begin
        for (int i = 0; i < mcc_pkg::AXES; i++)
        begin
            range_val[i] = max_reg[i] - min_reg[i];
            mid_sum[i]   = (DW+1)'(max_reg[i]) + (DW+1)'(min_reg[i]);
            mid_val[i]   = DW'(mid_sum[i] >>> 1);
        end
        sum_val  = mcc_pkg::SUM_W'(range_val[0]) + mcc_pkg::SUM_W'(range_val[1])
                 + mcc_pkg::SUM_W'(range_val[2]);
        any_zero = (range_val[0] == '0) || (range_val[1] == '0) || (range_val[2] == '0);
        den_val  = {range_val[cmd.axis], 1'b0} + mcc_pkg::DEN_W'(range_val[cmd.axis]);
        num_val  = {sum_val, {mcc_pkg::FRAC_BITS{1'b0}}};
        // The quotient overflows 16 bits exactly when num >= den * 2^16.
        ovf_val  = ({{(mcc_pkg::CMP_W - mcc_pkg::NUM_W){1'b0}}, num_val} >= {den_val, {DW{1'b0}}});
    end

    // One restoring division step: shift in the next numerator bit, subtract if it fits.
    always_comb
    begin
        trial    = {rem_reg, num_lo_reg[DW-1]};
        diff     = trial - {1'b0, den_reg};
        take     = (trial >= {1'b0, den_reg});
        rem_next = take ? diff[mcc_pkg::DEN_W-1:0] : trial[mcc_pkg::DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mcc_pkg::AXES; i++)
            begin
                off_reg[i]  <= '0;
                gain_reg[i] <= mcc_pkg::GAIN_ONE;
                max_reg[i]  <= '0;
                min_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    mcc_pkg::REG_OFFSET_X: off_reg[0]  <= cfg_data;
                    mcc_pkg::REG_OFFSET_Y: off_reg[1]  <= cfg_data;
                    mcc_pkg::REG_OFFSET_Z: off_reg[2]  <= cfg_data;
                    mcc_pkg::REG_GAIN_X:   gain_reg[0] <= cfg_data;
                    mcc_pkg::REG_GAIN_Y:   gain_reg[1] <= cfg_data;
                    mcc_pkg::REG_GAIN_Z:   gain_reg[2] <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            // The minimum is only checked when the maximum did not move.
            if (cmd.upd)
            begin
                if (corr_val >= max_reg[cmd.axis])
                begin
                    max_reg[cmd.axis] <= corr_val;
                end
                else if (corr_val <= min_reg[cmd.axis])
                begin
                    min_reg[cmd.axis] <= corr_val;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            raw_reg[0] <= in_data.raw_x;
            raw_reg[1] <= in_data.raw_y;
            raw_reg[2] <= in_data.raw_z;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.upd)
        begin
            corr_reg[cmd.axis] <= corr_val;
        end
        if (cmd.div_load)
        begin
            den_reg    <= den_val;
            rem_reg    <= mcc_pkg::DEN_W'(num_val[mcc_pkg::NUM_W-1:DW]);
            num_lo_reg <= num_val[DW-1:0];
            quo_reg    <= '0;
            sat_reg    <= ovf_val || (den_val == '0);
        end
        if (cmd.div_step)
        begin
            rem_reg    <= rem_next;
            num_lo_reg <= {num_lo_reg[DW-2:0], 1'b0};
            quo_reg    <= {quo_reg[DW-2:0], take};
        end
        if (cmd.div_store)
        begin
            scale_reg[cmd.axis] <= sat_reg ? mcc_pkg::SCALE_MAX : quo_reg;
        end
        if (cmd.out_load)
        begin
            out_reg.corr_x      <= corr_reg[0];
            out_reg.corr_y      <= corr_reg[1];
            out_reg.corr_z      <= corr_reg[2];
            out_reg.cal_off_x   <= mid_val[0];
            out_reg.cal_off_y   <= mid_val[1];
            out_reg.cal_off_z   <= mid_val[2];
            out_reg.cal_scale_x <= scale_reg[0];
            out_reg.cal_scale_y <= scale_reg[1];
            out_reg.cal_scale_z <= scale_reg[2];
            out_reg.range_zero  <= any_zero;
        end
    end

    assign out_data = out_reg;

endmodule

// File: rtl/core/magnetometer_correct_and_calibrate.sv
// Items are worked one at a time: in_stall stays high from acceptance until the result is
// loaded. The shared multiplier corrects each axis in turn, then the serial divider works
// through each axis (load, 16 quotient bits, store); the result load waits on a stalled output.
// An item may be accepted while the previous result still waits in the output register.
// Reset (rst_n, asynchronous, active low) clears the control state, the offsets to 0,
// the gains to 1.0 and the tracked minima and maxima to 0.
module magnetometer_correct_and_calibrate (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  mcc_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output mcc_pkg::out_item_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mcc_pkg::DATA_W-1:0]      cfg_data
);

    mcc_pkg::mcc_cmd_t cmd;

    assign cfg_ready = 1'b1;

    mcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    mcc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule

// File: rtl/core/mcc_checker.sv
// Port-level checks for the magnetometer correction and calibration block.
// Bound to the top level; depends on mcc_pkg.
module mcc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input mcc_pkg::out_item_t            out_data
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Once an item is taken the block is busy with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block took a second item while working");

    // A new result appears only at the end of an item's work.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work in progress");

    // A zero range forces at least one scale to full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.range_zero |->
            (out_data.cal_scale_x == mcc_pkg::SCALE_MAX) ||
            (out_data.cal_scale_y == mcc_pkg::SCALE_MAX) ||
            (out_data.cal_scale_z == mcc_pkg::SCALE_MAX))
        else $error("zero range without full-scale output");

endmodule

bind magnetometer_correct_and_calibrate mcc_checker u_mcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// File: sim/mag_cal_checker.sv
// Checker for the magnetometer correction and calibration block: watches the sample,
// result and register channels, predicts each result and compares it field by field.
// Depends on mcc_pkg for the item structs, register codes and FRAC_BITS.
module mag_cal_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  mcc_pkg::in_item_t              in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  mcc_pkg::out_item_t             out_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [mcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcc_pkg::DATA_W-1:0]     cfg_data,
    output int                             failures,
    output int                             waiting,
    output int                             compared
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [mcc_pkg::DATA_W-1:0] hard_iron [mcc_pkg::AXES];
    logic        [mcc_pkg::DATA_W-1:0] soft_gain [mcc_pkg::AXES];
    logic signed [mcc_pkg::DATA_W-1:0] trk_max [mcc_pkg::AXES];
    logic signed [mcc_pkg::DATA_W-1:0] trk_min [mcc_pkg::AXES];
    mcc_pkg::out_item_t                expected_results [$];

    // Corrects one sample, advances the min/max tracking and derives the calibration.
    function automatic mcc_pkg::out_item_t correct_and_track(input mcc_pkg::in_item_t s);
        logic signed [mcc_pkg::DATA_W-1:0] raw [mcc_pkg::AXES];
        logic signed [mcc_pkg::DATA_W-1:0] corr [mcc_pkg::AXES];
        logic signed [mcc_pkg::DATA_W-1:0] mid [mcc_pkg::AXES];
        logic        [mcc_pkg::DATA_W-1:0] scale [mcc_pkg::AXES];
        longint                            span [mcc_pkg::AXES];
        longint                            prod;
        longint                            total;
        longint                            quot;
        logic                              any_flat;
        mcc_pkg::out_item_t                r;
        raw[0] = s.raw_x;
        raw[1] = s.raw_y;
        raw[2] = s.raw_z;
        total = 0;
        any_flat = 1'b0;
        for (int i = 0; i < mcc_pkg::AXES; i++)
        begin
            prod = (longint'(raw[i]) - longint'(hard_iron[i])) * longint'(soft_gain[i]);
            prod = prod >>> mcc_pkg::FRAC_BITS;
            if (prod > 32767)
                prod = 32767;
            else if (prod < -32768)
                prod = -32768;
            corr[i] = mcc_pkg::DATA_W'(prod);
            // The minimum is only looked at when the maximum did not move.
            if (corr[i] >= trk_max[i])
                trk_max[i] = corr[i];
            else if (corr[i] <= trk_min[i])
                trk_min[i] = corr[i];
        end
        for (int i = 0; i < mcc_pkg::AXES; i++)
        begin
            span[i] = longint'(trk_max[i]) - longint'(trk_min[i]);
            total += span[i];
        end
        for (int i = 0; i < mcc_pkg::AXES; i++)
        begin
            mid[i] = mcc_pkg::DATA_W'((longint'(trk_max[i]) + longint'(trk_min[i])) >>> 1);
            if (span[i] == 0)
            begin
                scale[i] = mcc_pkg::SCALE_MAX;
                any_flat = 1'b1;
            end
            else
            begin
                quot = (total << mcc_pkg::FRAC_BITS) / (3 * span[i]);
                scale[i] = (quot > 65535) ? mcc_pkg::SCALE_MAX : mcc_pkg::DATA_W'(quot);
            end
        end
        r.corr_x      = corr[0];
        r.corr_y      = corr[1];
        r.corr_z      = corr[2];
        r.cal_off_x   = mid[0];
        r.cal_off_y   = mid[1];
        r.cal_off_z   = mid[2];
        r.cal_scale_x = scale[0];
        r.cal_scale_y = scale[1];
        r.cal_scale_z = scale[2];
        r.range_zero  = any_flat;
        return r;
    endfunction

    task automatic check_field(input string label, input int want, input int got);
        if (want != got)
        begin
            failures++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    task automatic compare_result(input mcc_pkg::out_item_t want,
                                  input mcc_pkg::out_item_t got);
        check_field("corr_x", int'(want.corr_x), int'(got.corr_x));
        check_field("corr_y", int'(want.corr_y), int'(got.corr_y));
        check_field("corr_z", int'(want.corr_z), int'(got.corr_z));
        check_field("cal_off_x", int'(want.cal_off_x), int'(got.cal_off_x));
        check_field("cal_off_y", int'(want.cal_off_y), int'(got.cal_off_y));
        check_field("cal_off_z", int'(want.cal_off_z), int'(got.cal_off_z));
        check_field("cal_scale_x", int'(want.cal_scale_x), int'(got.cal_scale_x));
        check_field("cal_scale_y", int'(want.cal_scale_y), int'(got.cal_scale_y));
        check_field("cal_scale_z", int'(want.cal_scale_z), int'(got.cal_scale_z));
        check_field("range_zero", int'(want.range_zero), int'(got.range_zero));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mcc_pkg::AXES; i++)
            begin
                hard_iron[i] = '0;
                soft_gain[i] = mcc_pkg::GAIN_ONE;
                trk_max[i]   = '0;
                trk_min[i]   = '0;
            end
            expected_results.delete();
            failures = 0;
            waiting  = 0;
            compared = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mcc_pkg::REG_OFFSET_X: hard_iron[0] = cfg_data;
                    mcc_pkg::REG_OFFSET_Y: hard_iron[1] = cfg_data;
                    mcc_pkg::REG_OFFSET_Z: hard_iron[2] = cfg_data;
                    mcc_pkg::REG_GAIN_X:   soft_gain[0] = cfg_data;
                    mcc_pkg::REG_GAIN_Y:   soft_gain[1] = cfg_data;
                    mcc_pkg::REG_GAIN_Z:   soft_gain[2] = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result, expected none, got corr %0d %0d %0d",
                             $time, out_data.corr_x, out_data.corr_y, out_data.corr_z);
                end
                else
                begin
                    compare_result(expected_results.pop_front(), out_data);
                    compared++;
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(correct_and_track(in_data));
            waiting = expected_results.size();
        end
    end

endmodule

// File: sim/testbench.sv
// Top of the magnetometer correction and calibration testbench: clock, reset, sample
// and register stimulus, random result back-pressure and the final verdict.
// Depends on mcc_pkg, the block itself and mag_cal_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [mcc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = mcc_pkg::REG_GAIN_Z + 3'd1;
    localparam logic [mcc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = mcc_pkg::REG_GAIN_Z + 3'd2;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    mcc_pkg::in_item_t             in_data;
    logic                          out_valid;
    logic                          out_stall;
    mcc_pkg::out_item_t            out_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [mcc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mcc_pkg::DATA_W-1:0]    cfg_data;

    int failures;
    int waiting;
    int compared;
    int samples_sent;
    int settings_used;
    int cycle_count;

    magnetometer_correct_and_calibrate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mag_cal_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .waiting   (waiting),
        .compared  (compared)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles with %0d results outstanding",
                     $time, CYCLE_LIMIT, waiting);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 4);
        if (r < 98)
            return $urandom_range(5, 40);
        return $urandom_range(100, 300);
    endfunction

    function automatic logic signed [mcc_pkg::DATA_W-1:0] rand_axis(input int amp);
        if ($urandom_range(0, 19) == 0)
            return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        return mcc_pkg::DATA_W'(int'($urandom_range(0, 2 * amp)) - amp);
    endfunction

    // The item stays on the bus, valid high, until the block takes it.
    task automatic send_sample(input mcc_pkg::in_item_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (in_stall);
        samples_sent++;
    endtask

    task automatic send_xyz(input int x, input int y, input int z);
        mcc_pkg::in_item_t s;
        s.raw_x = mcc_pkg::DATA_W'(x);
        s.raw_y = mcc_pkg::DATA_W'(y);
        s.raw_z = mcc_pkg::DATA_W'(z);
        send_sample(s);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (waiting != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [mcc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mcc_pkg::DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic program_regs(input int ox, input int oy, input int oz,
                                input int gx, input int gy, input int gz,
                                input bit poke_unmapped);
        wait_idle();
        reg_write(mcc_pkg::REG_OFFSET_X, mcc_pkg::DATA_W'(ox));
        reg_write(mcc_pkg::REG_OFFSET_Y, mcc_pkg::DATA_W'(oy));
        reg_write(mcc_pkg::REG_OFFSET_Z, mcc_pkg::DATA_W'(oz));
        reg_write(mcc_pkg::REG_GAIN_X, mcc_pkg::DATA_W'(gx));
        reg_write(mcc_pkg::REG_GAIN_Y, mcc_pkg::DATA_W'(gy));
        reg_write(mcc_pkg::REG_GAIN_Z, mcc_pkg::DATA_W'(gz));
        if (poke_unmapped)
        begin
            reg_write(REG_UNMAPPED_LO, mcc_pkg::DATA_W'($urandom));
            reg_write(REG_UNMAPPED_HI, mcc_pkg::DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input int count, input int amp);
        mcc_pkg::in_item_t s;
        repeat (count)
        begin
            s.raw_x = rand_axis(amp);
            s.raw_y = rand_axis(amp);
            s.raw_z = rand_axis(amp);
            send_sample(s);
        end
    endtask

    function automatic int rand_offset(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Result side: mostly short random stalls, some long ones, quiet stretches, and
    // one long hold-off that backs the block up into its sample input.
    initial
    begin
        int  hold;
        int  quiet;
        int  r;
        bit  long_done;
        hold = 0;
        quiet = 0;
        long_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (quiet > 0)
            begin
                quiet--;
                out_stall <= 1'b0;
            end
            else if (!long_done && compared >= 400)
            begin
                long_done = 1'b1;
                hold = 700;
                out_stall <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                begin
                    hold = $urandom_range(0, 3);
                    out_stall <= 1'b1;
                end
                else if (r < 23)
                begin
                    hold = $urandom_range(20, 120);
                    out_stall <= 1'b1;
                end
                else if (r < 25)
                begin
                    quiet = $urandom_range(100, 400);
                    out_stall <= 1'b0;
                end
                else
                begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        samples_sent  = 0;
        settings_used = 1;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= mcc_pkg::REG_OFFSET_X;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: all ranges flat first, then one tiny range against two
        // wide ones so that the scale quotient overflows.
        send_xyz(0, 0, 0);
        send_xyz(1, 100, -100);
        send_xyz(-1, -100, 100);
        send_xyz(2, 3, -4);
        send_xyz(0, -1, 1);

        // Zero gains with extreme offsets: raw extremes must all correct to zero.
        program_regs(-32768, 32767, 0, 0, 0, 0, 1'b0);
        send_xyz(32767, -32768, 21845);
        send_xyz(-32768, 32767, -21846);
        send_xyz(-1, 0, 1);

        // Half gain rounds odd negatives down; the largest gain saturates z both ways.
        program_regs(100, -100, 0, mcc_pkg::GAIN_ONE, mcc_pkg::GAIN_ONE / 2, 65535, 1'b0);
        send_xyz(-3, -3, 32767);
        send_xyz(3, 3, -32768);
        send_xyz(101, -99, -1);
        send_xyz(-7, -101, 0);

        program_regs(0, 0, 0, mcc_pkg::GAIN_ONE, mcc_pkg::GAIN_ONE, mcc_pkg::GAIN_ONE, 1'b0);
        run_phase(155, 300);
        program_regs(rand_offset(500), rand_offset(500), rand_offset(500),
                     $urandom_range(8192, 24576), $urandom_range(8192, 24576),
                     $urandom_range(8192, 24576), 1'b0);
        run_phase(155, 3000);
        program_regs(rand_offset(2000), rand_offset(2000), rand_offset(2000),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), 1'b1);
        run_phase(155, 12000);
        program_regs(rand_offset(8000), rand_offset(8000), rand_offset(8000),
                     $urandom_range(4096, 32768), $urandom_range(4096, 32768),
                     $urandom_range(4096, 32768), 1'b0);
        run_phase(155, 32768);
        program_regs(rand_offset(32768), rand_offset(32768), rand_offset(32768),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), 1'b0);
        run_phase(155, 32768);
        program_regs(32767, -32768, 32767, 65535, 65535, 1, 1'b1);
        run_phase(155, 32768);
        program_regs(0, 0, -32768, 0, mcc_pkg::GAIN_ONE, 65535, 1'b0);
        run_phase(155, 32768);

        wait_idle();
        repeat (70) @(posedge clk);
        @(negedge clk);
        $display("Sent %0d samples under %0d register settings; %0d results compared.",
                 samples_sent, settings_used, compared);
        $display("Covered flat ranges, scale overflow, correction saturation and back-pressure.");
        if (failures == 0 && waiting == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
